@@ src/prdo_pkg.sv @@
// ----------------------------------------------------------------------------
// prdo_pkg
// Shared constants, types and helpers for the packet ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package prdo_pkg;

  localparam int CAPACITY         = 8;
  localparam int MAX_PACKET_BYTES = 64;
  localparam int SLOTS            = CAPACITY + 1;
  localparam int MEM_DEPTH        = SLOTS * MAX_PACKET_BYTES;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_W    = 7;
  localparam int QUEUED_W = 4;
  localparam int STAT_W   = 32;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [QUEUED_W-1:0] queued_t;
  typedef logic [STAT_W-1:0]   stat_t;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_STATS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_PUSH  = 2'd0,
    REPLY_POP   = 2'd1,
    REPLY_STATS = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERSIZED = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  typedef struct packed {
    logic pushed;
    logic popped;
    logic dropped;
    logic oversized;
  } stat_inc_t;

  typedef struct packed {
    stat_t pushed;
    stat_t popped;
    stat_t dropped;
    stat_t oversized;
  } stat_cnt_t;

  typedef struct packed {
    reply_e     reply_kind;
    status_e    status;
    logic [7:0] out_byte;
    logic       last;
    len_t       packet_length;
    stat_cnt_t  totals;
    queued_t    queued_now;
  } rsp_t;

  function automatic slot_t next_slot(input slot_t s);
    return (s == slot_t'(SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

  function automatic addr_t slot_base(input slot_t s);
    return addr_t'(s) * addr_t'(MAX_PACKET_BYTES);
  endfunction

endpackage

`default_nettype wire

@@ src/prdo_if.sv @@
// ----------------------------------------------------------------------------
// prdo_if
// Request and response channels of the packet ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface prdo_req_if;
  import prdo_pkg::*;

  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] data_byte;
  logic       last_byte;
  len_t       max_length;

  modport source(output valid, kind, data_byte, last_byte, max_length, input ready);
  modport sink(input valid, kind, data_byte, last_byte, max_length, output ready);
endinterface

interface prdo_rsp_if;
  import prdo_pkg::*;

  logic       valid;
  logic       ready;
  reply_e     reply_kind;
  status_e    status;
  logic [7:0] out_byte;
  logic       last;
  len_t       packet_length;
  stat_t      pushed_total;
  stat_t      popped_total;
  stat_t      dropped_total;
  stat_t      oversized_total;
  queued_t    queued_now;

  modport source(output valid, reply_kind, status, out_byte, last, packet_length,
                 pushed_total, popped_total, dropped_total, oversized_total,
                 queued_now, input ready);
  modport sink(input valid, reply_kind, status, out_byte, last, packet_length,
               pushed_total, popped_total, dropped_total, oversized_total,
               queued_now, output ready);
endinterface

`default_nettype wire

@@ src/packet_ring_drop_oldest_top.sv @@
// ----------------------------------------------------------------------------
// packet_ring_drop_oldest_top
// Ring queue of variable-length packets, dropping the oldest on overflow.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  req      in   valid/ready  kind, data_byte, last_byte, max_length
//  rsp      out  valid/ready  reply_kind, status, out_byte, last, packet_length,
//                             pushed/popped/dropped/oversized_total, queued_now
//
//  push, clear, stats and rejected pops finish when accepted; a result is registered
//  pop ok, once accepted, sends one byte per cycle while rsp is not stalled,
//  paced by the single read port of the byte store and the byte sequencer
//  rsp stalls hold the output register; req is taken only when it is free
//  rst is synchronous; byte and length stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module packet_ring_drop_oldest_top (
  input  logic        clk,
  input  logic        rst,
  prdo_req_if.sink    req,
  prdo_rsp_if.source  rsp
);
  import prdo_pkg::*;

  state_e    state, state_next;
  slot_t     read_slot, read_slot_next;
  slot_t     write_slot, write_slot_next;
  cnt_t      packet_count, packet_count_next;
  len_t      bytes_received, bytes_received_next;
  logic      oversize_flag, oversize_flag_next;
  len_t      idx, idx_next;
  len_t      pop_len, pop_len_next;
  logic      rsp_valid, rsp_valid_next;
  rsp_t      rsp_data, rsp_data_next;

  logic      out_free;
  logic      req_ready;
  logic      accept;
  logic      pop_send;
  logic      pop_final;
  logic      pop_go;
  logic      byte_fits;
  logic      queue_full;
  len_t      head_len;
  len_t      commit_len;

  logic [7:0] mem [MEM_DEPTH];
  len_t       len_mem [SLOTS];
  logic       mem_we;
  logic       len_we;
  addr_t      wr_addr;
  addr_t      rd_addr;
  logic [7:0] rd_data;

  stat_inc_t inc;
  stat_cnt_t cnt;

  prdo_stats u_stats (
    .clk (clk),
    .rst (rst),
    .inc (inc),
    .cnt (cnt)
  );

  // head length, clamped to a slot
  always_comb begin
    head_len = len_mem[read_slot];
    if (head_len > len_t'(MAX_PACKET_BYTES)) begin
      head_len = len_t'(MAX_PACKET_BYTES);
    end
  end

  assign queue_full = (packet_count >= cnt_t'(CAPACITY));
  assign byte_fits  = !oversize_flag && (bytes_received != len_t'(MAX_PACKET_BYTES));
  assign commit_len = len_t'(bytes_received + 1'b1);
  assign pop_go     = accept && (req.kind == KIND_POP) && (packet_count != '0) &&
                      (head_len <= req.max_length);

  // control outputs
  always_comb begin
    out_free  = !rsp_valid || rsp.ready;
    req_ready = (state == S_IDLE) && out_free;
    accept    = req.valid && req_ready;
    pop_send  = (state == S_POP) && out_free;
    pop_final = pop_send && (len_t'(idx + 1'b1) == pop_len);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_go) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (pop_final) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    read_slot_next      = read_slot;
    write_slot_next     = write_slot;
    packet_count_next   = packet_count;
    bytes_received_next = bytes_received;
    oversize_flag_next  = oversize_flag;
    idx_next            = idx;
    pop_len_next        = pop_len;
    rsp_valid_next      = rsp_valid && !rsp.ready;
    rsp_data_next       = rsp_data;
    mem_we              = 1'b0;
    len_we              = 1'b0;
    inc                 = '0;

    if (accept) begin
      unique case (req.kind)
        KIND_PUSH: begin
          if (byte_fits) begin
            mem_we              = 1'b1;
            bytes_received_next = commit_len;
          end else begin
            oversize_flag_next = 1'b1;
          end
          if (req.last_byte) begin
            rsp_valid_next            = 1'b1;
            rsp_data_next             = '0;
            rsp_data_next.reply_kind  = REPLY_PUSH;
            rsp_data_next.last        = 1'b1;
            bytes_received_next       = '0;
            oversize_flag_next        = 1'b0;
            if (!byte_fits) begin
              inc.oversized        = 1'b1;
              rsp_data_next.status = STATUS_OVERSIZED;
            end else begin
              len_we                      = 1'b1;
              write_slot_next             = next_slot(write_slot);
              inc.pushed                  = 1'b1;
              rsp_data_next.status        = STATUS_OK;
              rsp_data_next.packet_length = commit_len;
              if (queue_full) begin
                read_slot_next = next_slot(read_slot);
                inc.dropped    = 1'b1;
              end else begin
                packet_count_next = cnt_t'(packet_count + 1'b1);
              end
            end
          end
        end
        KIND_POP: begin
          idx_next     = '0;
          pop_len_next = head_len;
          if (packet_count == '0) begin
            rsp_valid_next           = 1'b1;
            rsp_data_next            = '0;
            rsp_data_next.reply_kind = REPLY_POP;
            rsp_data_next.status     = STATUS_EMPTY;
            rsp_data_next.last       = 1'b1;
          end else if (head_len > req.max_length) begin
            rsp_valid_next              = 1'b1;
            rsp_data_next               = '0;
            rsp_data_next.reply_kind    = REPLY_POP;
            rsp_data_next.status        = STATUS_TOO_LONG;
            rsp_data_next.last          = 1'b1;
            rsp_data_next.packet_length = head_len;
          end
        end
        KIND_CLEAR: begin
          read_slot_next      = '0;
          write_slot_next     = '0;
          packet_count_next   = '0;
          bytes_received_next = '0;
          oversize_flag_next  = 1'b0;
        end
        KIND_STATS: begin
          rsp_valid_next           = 1'b1;
          rsp_data_next            = '0;
          rsp_data_next.reply_kind = REPLY_STATS;
          rsp_data_next.status     = STATUS_OK;
          rsp_data_next.last       = 1'b1;
          rsp_data_next.totals     = cnt;
          rsp_data_next.queued_now = queued_t'(packet_count);
        end
        default: begin
          rsp_valid_next = rsp_valid && !rsp.ready;
        end
      endcase
    end

    if (pop_send) begin
      rsp_valid_next              = 1'b1;
      rsp_data_next               = '0;
      rsp_data_next.reply_kind    = REPLY_POP;
      rsp_data_next.status        = STATUS_OK;
      rsp_data_next.out_byte      = rd_data;
      rsp_data_next.last          = pop_final;
      rsp_data_next.packet_length = pop_len;
      idx_next                    = len_t'(idx + 1'b1);
      if (pop_final) begin
        idx_next          = '0;
        read_slot_next    = next_slot(read_slot);
        packet_count_next = cnt_t'(packet_count - 1'b1);
        inc.popped        = 1'b1;
      end
    end
  end

  // rd_data is read at idx_next of the head slot, so it holds the byte at idx while a pop sends
  assign wr_addr = addr_t'(slot_base(write_slot) + addr_t'(bytes_received));
  assign rd_addr = addr_t'(slot_base(read_slot) + addr_t'(idx_next));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= req.data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[write_slot] <= commit_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      read_slot      <= '0;
      write_slot     <= '0;
      packet_count   <= '0;
      bytes_received <= '0;
      oversize_flag  <= 1'b0;
      idx            <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      read_slot      <= read_slot_next;
      write_slot     <= write_slot_next;
      packet_count   <= packet_count_next;
      bytes_received <= bytes_received_next;
      oversize_flag  <= oversize_flag_next;
      idx            <= idx_next;
      rsp_valid      <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_len  <= pop_len_next;
    rsp_data <= rsp_data_next;
  end

  assign req.ready           = req_ready;
  assign rsp.valid           = rsp_valid;
  assign rsp.reply_kind      = rsp_data.reply_kind;
  assign rsp.status          = rsp_data.status;
  assign rsp.out_byte        = rsp_data.out_byte;
  assign rsp.last            = rsp_data.last;
  assign rsp.packet_length   = rsp_data.packet_length;
  assign rsp.pushed_total    = rsp_data.totals.pushed;
  assign rsp.popped_total    = rsp_data.totals.popped;
  assign rsp.dropped_total   = rsp_data.totals.dropped;
  assign rsp.oversized_total = rsp_data.totals.oversized;
  assign rsp.queued_now      = rsp_data.queued_now;

endmodule

`default_nettype wire

@@ src/prdo_stats.sv @@
// ----------------------------------------------------------------------------
// prdo_stats
// Wrapping packet counters: pushed, popped, dropped and oversized.
// ----------------------------------------------------------------------------
`default_nettype none

module prdo_stats (
  input  logic                clk,
  input  logic                rst,
  input  prdo_pkg::stat_inc_t inc,
  output prdo_pkg::stat_cnt_t cnt
);
  import prdo_pkg::*;

  stat_cnt_t cnt_next;

  always_comb begin
    cnt_next = cnt;
    if (inc.pushed) begin
      cnt_next.pushed = cnt.pushed + 1'b1;
    end
    if (inc.popped) begin
      cnt_next.popped = cnt.popped + 1'b1;
    end
    if (inc.dropped) begin
      cnt_next.dropped = cnt.dropped + 1'b1;
    end
    if (inc.oversized) begin
      cnt_next.oversized = cnt.oversized + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ src/prdo_checker.sv @@
// ----------------------------------------------------------------------------
// prdo_checker
// Port-level checks on the response channel of the packet ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

module prdo_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input prdo_pkg::reply_e  reply_kind,
  input prdo_pkg::status_e status,
  input logic [7:0]        out_byte,
  input logic              last,
  input prdo_pkg::len_t    packet_length,
  input prdo_pkg::queued_t queued_now
);
  import prdo_pkg::*;

  // no transaction offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(reply_kind) && $stable(status) &&
      $stable(out_byte) && $stable(last) && $stable(packet_length))
    else $error("stalled response changed");

  // stats reply is a single ok transaction
  a_stats_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reply_kind == REPLY_STATS |-> last && status == STATUS_OK)
    else $error("malformed statistics reply");

  // only pop data carries a byte, only stats carry a queue count
  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reply_kind != REPLY_POP |-> out_byte == '0 &&
      (reply_kind == REPLY_STATS || queued_now == '0))
    else $error("unused response field not zero");

endmodule

bind packet_ring_drop_oldest_top prdo_checker u_prdo_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .reply_kind    (rsp.reply_kind),
  .status        (rsp.status),
  .out_byte      (rsp.out_byte),
  .last          (rsp.last),
  .packet_length (rsp.packet_length),
  .queued_now    (rsp.queued_now)
);

`default_nettype wire

@@ dv/tb_packet_ring_drop_oldest_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_ring_drop_oldest_top
// Self-checking bench for the drop-oldest packet ring. A short directed table
// covers empty and full queues, the largest and oversized packets, too-long
// pops, clear and statistics. Random packet traffic follows under three idle
// profiles. A shadow ring predicts every response transaction.
// ----------------------------------------------------------------------------
module tb_packet_ring_drop_oldest_top;
  import prdo_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PLAN_ROWS    = 21;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] first;
    int         nbytes;
    logic       last;
    len_t       max_len;
    int         times;
    logic       pinned;
    status_e    pin_status;
    len_t       pin_len;
  } plan_row_t;

  logic clk;
  logic rst;

  prdo_req_if req_ch();
  prdo_rsp_if rsp_ch();

  packet_ring_drop_oldest_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [7:0] ring_bytes [SLOTS][MAX_PACKET_BYTES];
  int         ring_lens [SLOTS];
  int         rd_slot;
  int         wr_slot;
  int         held;
  int         rx_count;
  logic       rx_over;
  stat_t      n_pushed;
  stat_t      n_popped;
  stat_t      n_dropped;
  stat_t      n_oversized;

  rsp_t       pending_rsp [$];
  plan_row_t  plan [PLAN_ROWS];
  int         errors;
  int         items_sent;
  int         rsps_seen;
  int         src_idle_pct;
  int         snk_stall_pct;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int advance_slot(input int s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  task automatic ring_model(input kind_e k, input logic [7:0] d, input logic l,
                            input len_t m);
    rsp_t r;
    int   len;
    r = '0;
    r.last = 1'b1;
    case (k)
      KIND_PUSH: begin
        if (!rx_over) begin
          if (rx_count < MAX_PACKET_BYTES) begin
            ring_bytes[wr_slot][rx_count] = d;
            rx_count++;
          end else begin
            rx_over = 1'b1;
          end
        end
        if (l) begin
          r.reply_kind = REPLY_PUSH;
          if (rx_over) begin
            r.status = STATUS_OVERSIZED;
            n_oversized++;
          end else begin
            if (held >= CAPACITY) begin
              rd_slot = advance_slot(rd_slot);
              held--;
              n_dropped++;
            end
            ring_lens[wr_slot] = rx_count;
            wr_slot = advance_slot(wr_slot);
            held++;
            n_pushed++;
            r.status = STATUS_OK;
            r.packet_length = len_t'(rx_count);
          end
          rx_count = 0;
          rx_over = 1'b0;
          pending_rsp.push_back(r);
        end
      end
      KIND_POP: begin
        r.reply_kind = REPLY_POP;
        if (held == 0) begin
          r.status = STATUS_EMPTY;
          pending_rsp.push_back(r);
        end else begin
          len = ring_lens[rd_slot];
          r.packet_length = len_t'(len);
          if (len > int'(m)) begin
            r.status = STATUS_TOO_LONG;
            pending_rsp.push_back(r);
          end else begin
            r.status = STATUS_OK;
            for (int i = 0; i < len; i++) begin
              r.out_byte = ring_bytes[rd_slot][i];
              r.last = (i == len - 1);
              pending_rsp.push_back(r);
            end
            rd_slot = advance_slot(rd_slot);
            held--;
            n_popped++;
          end
        end
      end
      KIND_CLEAR: begin
        rd_slot = 0;
        wr_slot = 0;
        held = 0;
        rx_count = 0;
        rx_over = 1'b0;
      end
      default: begin
        r.reply_kind = REPLY_STATS;
        r.status = STATUS_OK;
        r.totals.pushed = n_pushed;
        r.totals.popped = n_popped;
        r.totals.dropped = n_dropped;
        r.totals.oversized = n_oversized;
        r.queued_now = queued_t'(held);
        pending_rsp.push_back(r);
      end
    endcase
  endtask

  task automatic send_item(input kind_e k, input logic [7:0] d, input logic l,
                           input len_t m);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.kind = k;
    req_ch.data_byte = d;
    req_ch.last_byte = l;
    req_ch.max_length = m;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    ring_model(k, d, l, m);
  endtask

  task automatic send_push_run(input logic [7:0] first, input int n, input logic l,
                               input logic rand_data);
    logic [7:0] d;
    for (int b = 0; b < n; b++) begin
      d = rand_data ? 8'($urandom_range(0, 255)) : 8'(first + b);
      send_item(KIND_PUSH, d, l && (b == n - 1), len_t'($urandom_range(0, 127)));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  initial begin : rsp_check
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        rsps_seen++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, actual kind %0d status %0d",
                   $time, rsp_ch.reply_kind, rsp_ch.status);
        end else begin
          want = pending_rsp.pop_front();
          check_field("reply_kind", want.reply_kind, rsp_ch.reply_kind);
          check_field("status", want.status, rsp_ch.status);
          check_field("out_byte", want.out_byte, rsp_ch.out_byte);
          check_field("last", want.last, rsp_ch.last);
          check_field("packet_length", want.packet_length, rsp_ch.packet_length);
          check_field("pushed_total", want.totals.pushed, rsp_ch.pushed_total);
          check_field("popped_total", want.totals.popped, rsp_ch.popped_total);
          check_field("dropped_total", want.totals.dropped, rsp_ch.dropped_total);
          check_field("oversized_total", want.totals.oversized, rsp_ch.oversized_total);
          check_field("queued_now", want.queued_now, rsp_ch.queued_now);
        end
      end
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d responses still outstanding", $time,
                 pending_rsp.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rsp_t       r;
    int         sel;
    int         n;
    int         plan_items;
    len_t       m;
    logic [7:0] d;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_PUSH;
    req_ch.data_byte = '0;
    req_ch.last_byte = 1'b0;
    req_ch.max_length = '0;
    src_idle_pct = 13;
    snk_stall_pct = 81;
    errors = 0;
    items_sent = 0;
    rsps_seen = 0;
    rd_slot = 0;
    wr_slot = 0;
    held = 0;
    rx_count = 0;
    rx_over = 1'b0;
    n_pushed = '0;
    n_popped = '0;
    n_dropped = '0;
    n_oversized = '0;

    plan = '{
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd64,  1, 1'b1, STATUS_EMPTY,     7'd0},
      '{KIND_STATS, 8'h00,  1, 1'b0, 7'd0,   1, 1'b1, STATUS_OK,        7'd0},
      '{KIND_PUSH,  8'h00,  1, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,        7'd1},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd0,   1, 1'b1, STATUS_TOO_LONG,  7'd1},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd127, 1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_PUSH,  8'hFF,  1, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,        7'd1},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd1,   1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_PUSH,  8'hC0, 64, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,        7'd64},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd63,  1, 1'b1, STATUS_TOO_LONG,  7'd64},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd64,  1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_PUSH,  8'h10, 65, 1'b1, 7'd0,   1, 1'b1, STATUS_OVERSIZED, 7'd0},
      '{KIND_PUSH,  8'h30,  3, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_CLEAR, 8'h00,  1, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd64,  1, 1'b1, STATUS_EMPTY,     7'd0},
      '{KIND_PUSH,  8'hAA,  2, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,        7'd2},
      '{KIND_PUSH,  8'h40,  1, 1'b1, 7'd0,   9, 1'b0, STATUS_OK,        7'd0},
      '{KIND_STATS, 8'h00,  1, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_POP,   8'h00,  1, 1'b0, 7'd64,  3, 1'b0, STATUS_OK,        7'd0},
      '{KIND_PUSH,  8'h7F,  1, 1'b1, 7'd0,   1, 1'b1, STATUS_OK,        7'd1},
      '{KIND_CLEAR, 8'h00,  1, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,        7'd0},
      '{KIND_STATS, 8'h00,  1, 1'b0, 7'd0,   1, 1'b0, STATUS_OK,        7'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      for (int t = 0; t < plan[i].times; t++) begin
        if (plan[i].kind == KIND_PUSH) begin
          send_push_run(plan[i].first, plan[i].nbytes, plan[i].last, 1'b0);
        end else begin
          send_item(plan[i].kind, 8'h00, 1'b0, plan[i].max_len);
        end
        if (plan[i].pinned) begin
          r = pending_rsp.pop_back();
          r.status = plan[i].pin_status;
          r.packet_length = plan[i].pin_len;
          pending_rsp.push_back(r);
        end
      end
    end
    plan_items = items_sent;

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 13;
          snk_stall_pct = 81;
        end
        1: begin
          src_idle_pct = 81;
          snk_stall_pct = 13;
        end
        default: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
      endcase
      while (items_sent < plan_items + RANDOM_ITEMS * (p + 1) / 3) begin
        sel = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        if (sel < 45) begin
          n = $urandom_range(0, 99);
          if (n < 70) begin
            n = $urandom_range(1, 8);
          end else if (n < 90) begin
            n = $urandom_range(9, MAX_PACKET_BYTES - 1);
          end else if (n < 95) begin
            n = MAX_PACKET_BYTES;
          end else begin
            n = $urandom_range(MAX_PACKET_BYTES + 1, MAX_PACKET_BYTES + 6);
          end
          send_push_run(8'h00, n, ($urandom_range(0, 19) != 0), 1'b1);
        end else if (sel < 80) begin
          if ($urandom_range(0, 3) == 0) begin
            m = len_t'($urandom_range(0, MAX_PACKET_BYTES));
          end else begin
            m = len_t'($urandom_range(MAX_PACKET_BYTES, 127));
          end
          send_item(KIND_POP, d, 1'($urandom_range(0, 1)), m);
        end else if (sel < 85) begin
          send_item(KIND_CLEAR, d, 1'($urandom_range(0, 1)), len_t'($urandom_range(0, 127)));
        end else if (sel < 93) begin
          send_item(KIND_STATS, d, 1'($urandom_range(0, 1)), len_t'($urandom_range(0, 127)));
        end else begin
          send_item(kind_e'($urandom_range(0, 3)), d, 1'($urandom_range(0, 1)),
                    len_t'($urandom_range(0, 127)));
        end
      end
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d request transactions (%0d directed), %0d responses checked",
             items_sent, plan_items, rsps_seen);
    $display("packets committed %0d, popped %0d, dropped %0d, oversized %0d, errors %0d",
             n_pushed, n_popped, n_dropped, n_oversized, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
